[hw/rtl/iafd_pkg.sv]
`default_nettype none
package iafd_pkg;

	localparam int unsigned DataW = 64;

	typedef enum logic [3:0] {
		K_LT   = 4'd0,
		K_LE   = 4'd1,
		K_GT   = 4'd2,
		K_GE   = 4'd3,
		K_EQ   = 4'd4,
		K_NE   = 4'd5,
		K_LAND = 4'd6,
		K_LOR  = 4'd7,
		K_ADD  = 4'd8,
		K_SUB  = 4'd9,
		K_MUL  = 4'd10,
		K_XOR  = 4'd11,
		K_AND  = 4'd12,
		K_OR   = 4'd13,
		K_DIV  = 4'd14,
		K_MOD  = 4'd15
	} kind_t;

	typedef struct packed {
		logic             vld;
		kind_t            kind;
		logic             sa;
		logic             sb;
		logic [DataW-1:0] bval;
		logic [DataW-1:0] res;
		logic [DataW-1:0] rem;
		logic [DataW-1:0] dvd;
		logic [DataW-1:0] mb;
	} stage_t;

endpackage
`default_nettype wire

[hw/rtl/iafd_div_step.sv]
`default_nettype none
module iafd_div_step import iafd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire stage_t d_in,
	output stage_t      d_out
);

	logic [DataW:0] t;
	logic [DataW:0] diff;
	logic           ge;
	stage_t         nxt;
	logic           vld_q;
	stage_t         dat_q;

	always_comb begin
		t    = {d_in.rem, d_in.dvd[DataW-1]};
		diff = t - {1'b0, d_in.mb};
		ge   = ~diff[DataW];
		nxt  = d_in;
		nxt.rem = ge ? diff[DataW-1:0] : t[DataW-1:0];
		nxt.dvd = {d_in.dvd[DataW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	always_comb begin
		d_out     = dat_q;
		d_out.vld = vld_q;
	end

endmodule
`default_nettype wire

[hw/rtl/integer_alu_floor_division_unit.sv]
`default_nettype none
// An input beat passes s1, s2, the divider stages, fx and the output register.
// Throughput: one beat per cycle unless the output stalls; 64 one-bit stages.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and sets the floor mode bit to 0.
module integer_alu_floor_division_unit import iafd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // left_value [63:0], right_value [127:64]
	input  wire logic [3:0]   s_tuser,  // kind [3:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // result_value [63:0]
	output logic [1:0]        m_tuser,  // is_boolean [0], divide_by_zero [1]
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [0:0]   cfg_data
);

	logic             en;
	logic             mode_q;
	logic             v_s1, v_s2, v_fx;
	kind_t            kind_s1, kind_s2, kind_fx;
	logic [DataW-1:0] a_s1, b_s1;
	logic             sa_s2, sb_s2;
	logic [DataW-1:0] b_s2, ma_s2, mb_s2, res_s2, pp0_s2;
	logic [31:0]      pp1_s2, pp2_s2;
	logic [31:0]      pp1_full, pp2_full;
	logic [DataW-1:0] res_c, ma_c, mb_c, mul_c;
	logic             lt_c, gt_c;
	logic [DataW-1:0] qs_fx, rs_fx, b_fx, res_fx;
	logic [DataW-1:0] q_c, r_c, qs_c, rs_c, fin_c;
	logic             dz_c;
	stage_t           pipe [0:64];

	assign en        = ~m_tvalid | m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_fx     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_fx     <= pipe[64].vld;
			m_tvalid <= v_fx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_t'(s_tuser);
			a_s1    <= s_tdata[63:0];
			b_s1    <= s_tdata[127:64];
		end
	end

	always_comb begin
		lt_c = $signed(a_s1) < $signed(b_s1);
		gt_c = $signed(b_s1) < $signed(a_s1);
		ma_c = a_s1[DataW-1] ? (DataW'(0) - a_s1) : a_s1;
		mb_c = b_s1[DataW-1] ? (DataW'(0) - b_s1) : b_s1;
		pp1_full = a_s1[31:0] * b_s1[63:32];
		pp2_full = a_s1[63:32] * b_s1[31:0];
		case (kind_s1)
			K_LT:    res_c = DataW'(lt_c);
			K_LE:    res_c = DataW'(!gt_c);
			K_GT:    res_c = DataW'(gt_c);
			K_GE:    res_c = DataW'(!lt_c);
			K_EQ:    res_c = DataW'(a_s1 == b_s1);
			K_NE:    res_c = DataW'(a_s1 != b_s1);
			K_LAND:  res_c = DataW'((|a_s1) & (|b_s1));
			K_LOR:   res_c = DataW'((|a_s1) | (|b_s1));
			K_ADD:   res_c = a_s1 + b_s1;
			K_SUB:   res_c = a_s1 - b_s1;
			K_XOR:   res_c = a_s1 ^ b_s1;
			K_AND:   res_c = a_s1 & b_s1;
			K_OR:    res_c = a_s1 | b_s1;
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			sa_s2   <= a_s1[DataW-1];
			sb_s2   <= b_s1[DataW-1];
			b_s2    <= b_s1;
			ma_s2   <= ma_c;
			mb_s2   <= mb_c;
			res_s2  <= res_c;
			pp0_s2  <= a_s1[31:0] * b_s1[31:0];
			pp1_s2  <= pp1_full;
			pp2_s2  <= pp2_full;
		end
	end

	always_comb begin
		mul_c = pp0_s2 + {pp1_s2 + pp2_s2, 32'd0};
		pipe[0].vld  = v_s2;
		pipe[0].kind = kind_s2;
		pipe[0].sa   = sa_s2;
		pipe[0].sb   = sb_s2;
		pipe[0].bval = b_s2;
		pipe[0].res  = (kind_s2 == K_MUL) ? mul_c : res_s2;
		pipe[0].rem  = '0;
		pipe[0].dvd  = ma_s2;
		pipe[0].mb   = mb_s2;
	end

	for (genvar i = 0; i < DataW; i++) begin : g_div
		iafd_div_step u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d_in  (pipe[i]),
			.d_out (pipe[i+1])
		);
	end

	always_comb begin
		q_c = pipe[64].dvd;
		r_c = pipe[64].rem;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_fx <= pipe[64].kind;
			b_fx    <= pipe[64].bval;
			res_fx  <= pipe[64].res;
			qs_fx   <= (pipe[64].sa ^ pipe[64].sb) ? (DataW'(0) - q_c) : q_c;
			rs_fx   <= pipe[64].sa ? (DataW'(0) - r_c) : r_c;
		end
	end

	always_comb begin
		qs_c = qs_fx;
		rs_c = rs_fx;
		if (mode_q && (|rs_fx) && (rs_fx[DataW-1] ^ b_fx[DataW-1])) begin
			rs_c = rs_fx + b_fx;
			qs_c = qs_fx - DataW'(1);
		end
		dz_c = 1'b0;
		case (kind_fx) inside
			K_DIV, K_MOD: begin
				dz_c  = ~(|b_fx);
				fin_c = dz_c ? '0 : ((kind_fx == K_DIV) ? qs_c : rs_c);
			end
			default: fin_c = res_fx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= fin_c;
			m_tuser <= {dz_c, kind_fx <= K_LOR};
		end
	end

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("zero divisor result is not zero");

	a_bool_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[63:1] == '0)
		else $error("boolean result out of range");

	a_dz_not_bool: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("boolean result flagged as zero divisor");

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import iafd_pkg::*;

	typedef struct {
		logic [63:0] val;
		logic [1:0]  flags;
	} alu_result_t;

	typedef struct {
		kind_t       kind;
		logic [63:0] a;
		logic [63:0] b;
		logic        typed;
		logic [63:0] val;
		logic [1:0]  flags;
	} vector_t;

	localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG1  = '1;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 80;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [3:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_data;

	logic         in_beat, out_beat, cfg_beat;
	logic [63:0]  out_val;
	logic [1:0]   out_flags;

	alu_result_t  pending_results[$];
	logic         floor_mode;
	int           stall_pct;
	int           errors;
	int           idle_cycles;

	integer_alu_floor_division_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Outputs only move at the rising edge, so the falling edge gives stable samples.
	always @(negedge clk) begin
		in_beat   <= s_tvalid && s_tready;
		out_beat  <= m_tvalid && m_tready;
		cfg_beat  <= cfg_valid && cfg_ready;
		out_val   <= m_tdata;
		out_flags <= m_tuser;
	end

	function automatic alu_result_t alu_predict(kind_t k, logic [63:0] a, logic [63:0] b,
			logic fm);
		alu_result_t r;
		logic [63:0] ma, mb, q, rm;
		r.flags = {1'b0, k <= K_LOR};
		r.val = '0;
		case (k)
			K_LT:   r.val = $signed(a) < $signed(b);
			K_LE:   r.val = $signed(a) <= $signed(b);
			K_GT:   r.val = $signed(a) > $signed(b);
			K_GE:   r.val = $signed(a) >= $signed(b);
			K_EQ:   r.val = a == b;
			K_NE:   r.val = a != b;
			K_LAND: r.val = (a != 0) && (b != 0);
			K_LOR:  r.val = (a != 0) || (b != 0);
			K_ADD:  r.val = a + b;
			K_SUB:  r.val = a - b;
			K_MUL:  r.val = a * b;
			K_XOR:  r.val = a ^ b;
			K_AND:  r.val = a & b;
			K_OR:   r.val = a | b;
			default: begin
				if (b == 0) begin
					r.flags[1] = 1'b1;
				end else begin
					ma = a[63] ? -a : a;
					mb = b[63] ? -b : b;
					q  = ma / mb;
					rm = ma % mb;
					if (a[63] != b[63]) q = -q;
					if (a[63]) rm = -rm;
					// Floor mode: a nonzero remainder must follow the sign of the divisor.
					if (fm && rm != 0 && rm[63] != b[63]) begin
						rm = rm + b;
						q  = q - 1;
					end
					r.val = (k == K_DIV) ? q : rm;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(9))
			0: return MIN_V;
			1: return MAX_V;
			2: return NEG1;
			3: return 64'($urandom_range(1));
			4: return 64'($signed($urandom_range(40)) - 20);
			5: return {{32{1'b0}}, 32'($urandom())};
			6: return {{40{1'b1}}, 24'($urandom())};
			default: return {32'($urandom()), 32'($urandom())};
		endcase
	endfunction

	task automatic send_item(kind_t k, logic [63:0] a, logic [63:0] b, int idle_pct,
			bit typed = 0, alu_result_t want = '{default: '0});
		alu_result_t exp_r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!in_beat);
		exp_r = typed ? want : alu_predict(k, a, b, floor_mode);
		pending_results.insert(pending_results.size(), exp_r);
	endtask

	task automatic drain_and_write(logic mode);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_beat);
		cfg_valid <= 1'b0;
		floor_mode = mode;
	endtask

	always @(posedge clk) begin
		alu_result_t got;
		if (arst_n) m_tready <= ($urandom_range(99) >= stall_pct);
		if (out_beat) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat val=%h flags=%b", $time, out_val, out_flags);
				errors++;
			end else begin
				got = pending_results.pop_front();
				if (got.val !== out_val) begin
					$display("%0t: result_value expected %h actual %h", $time, got.val, out_val);
					errors++;
				end
				if (got.flags[0] !== out_flags[0]) begin
					$display("%0t: is_boolean expected %b actual %b", $time, got.flags[0],
						out_flags[0]);
					errors++;
				end
				if (got.flags[1] !== out_flags[1]) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						got.flags[1], out_flags[1]);
					errors++;
				end
			end
		end
		idle_cycles = (in_beat || out_beat || cfg_beat) ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		vector_t vectors[$];
		int idle_pcts[4];
		int stall_pcts[4];
		int phase;
		kind_t k;
		idle_pcts  = '{0, 76, 0, 9};
		stall_pcts = '{0, 0, 76, 9};
		errors = 0;
		idle_cycles = 0;
		floor_mode = 1'b0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_beat = 1'b0;
		out_beat = 1'b0;
		cfg_beat = 1'b0;
		vectors = '{
			'{K_LT,   MIN_V, MAX_V, 1, 64'd1, 2'b01},
			'{K_LE,   MAX_V, MAX_V, 1, 64'd1, 2'b01},
			'{K_GT,   NEG1,  64'd0, 1, 64'd0, 2'b01},
			'{K_GE,   MIN_V, MIN_V, 1, 64'd1, 2'b01},
			'{K_EQ,   NEG1,  NEG1,  1, 64'd1, 2'b01},
			'{K_NE,   64'd0, MIN_V, 1, 64'd1, 2'b01},
			'{K_LAND, 64'd5, NEG1,  1, 64'd1, 2'b01},
			'{K_LAND, 64'd5, 64'd0, 1, 64'd0, 2'b01},
			'{K_LOR,  64'd0, MIN_V, 1, 64'd1, 2'b01},
			'{K_LOR,  64'd0, 64'd0, 1, 64'd0, 2'b01},
			'{K_ADD,  MAX_V, 64'd1, 1, MIN_V, 2'b00},
			'{K_SUB,  MIN_V, 64'd1, 1, MAX_V, 2'b00},
			'{K_MUL,  MIN_V, NEG1,  1, MIN_V, 2'b00},
			'{K_XOR,  MAX_V, NEG1,  1, MIN_V, 2'b00},
			'{K_AND,  NEG1,  MAX_V, 1, MAX_V, 2'b00},
			'{K_OR,   MIN_V, MAX_V, 1, NEG1,  2'b00},
			'{K_DIV,  MAX_V, 64'd0, 1, 64'd0, 2'b10},
			'{K_MOD,  MIN_V, 64'd0, 1, 64'd0, 2'b10},
			'{K_DIV,  MIN_V, NEG1,  1, MIN_V, 2'b00},
			'{K_MOD,  MIN_V, NEG1,  1, 64'd0, 2'b00},
			'{K_DIV,  -64'd7, 64'd2, 0, '0, '0},
			'{K_MOD,  -64'd7, 64'd2, 0, '0, '0},
			'{K_DIV,  64'd7, -64'd2, 0, '0, '0},
			'{K_MOD,  64'd7, -64'd2, 0, '0, '0},
			'{K_MUL,  MAX_V, MAX_V, 0, '0, '0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i])
			send_item(vectors[i].kind, vectors[i].a, vectors[i].b, 0, vectors[i].typed,
				'{vectors[i].val, vectors[i].flags});

		// The table again under floor mode, checked against the predictor.
		drain_and_write(1'b1);
		foreach (vectors[i]) send_item(vectors[i].kind, vectors[i].a, vectors[i].b, 0);

		for (phase = 0; phase < 8; phase++) begin
			drain_and_write(phase[1] ^ phase[0]);
			stall_pct = stall_pcts[phase % 4];
			repeat (170) begin
				k = kind_t'($urandom_range(int'(K_MOD)));
				if ($urandom_range(1)) k = kind_t'($urandom_range(int'(K_DIV), int'(K_MOD)));
				send_item(k, pick_operand(), pick_operand(), idle_pcts[phase % 4]);
			end
		end

		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
